/* hdl/xs4k_pkg.sv */
// ----------------------------------------------------------------------------
// xs4k_pkg
// shared types, constants and register indexes of the xorshift-star generator
// ----------------------------------------------------------------------------
`default_nettype none

package xs4k_pkg;

  localparam int STATE_WORDS_DEF = 64;
  localparam int WORD_W          = 64;
  localparam int HALF_W          = 32;
  localparam int SHIFT_W         = 6;
  localparam int INDEX_W         = 6;
  localparam int CMD_W           = 2;
  localparam int CFG_INDEX_W     = 3;
  localparam int QUEUE_DEPTH     = 4;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HALF = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_A    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_B    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_C    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE    = 3'd4;

  // reset values of the configuration registers
  localparam logic [SHIFT_W-1:0] SHIFT_A_RST    = 6'd23;
  localparam logic [SHIFT_W-1:0] SHIFT_B_RST    = 6'd11;
  localparam logic [SHIFT_W-1:0] SHIFT_C_RST    = 6'd30;
  localparam logic [WORD_W-1:0]  MULTIPLIER_RST = 64'd2685821657736338717;
  localparam logic               REVERSE_RST    = 1'b1;

  // classified operation carried from the front to the back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_LOW,
    OP_HIGH
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  seed;
  } item_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
  } ring_out_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift_a;
    logic [SHIFT_W-1:0] shift_b;
    logic [SHIFT_W-1:0] shift_c;
    logic [WORD_W-1:0]  multiplier;
    logic               reverse_enable;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/xs4k_front.sv */
// ----------------------------------------------------------------------------
// xs4k_front
// accepts commands, tracks the half toggle and classifies each transaction
// ----------------------------------------------------------------------------
`default_nettype none

module xs4k_front #(
  parameter int STATE_WORDS = xs4k_pkg::STATE_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [xs4k_pkg::CMD_W-1:0]   command,
  input  wire logic [xs4k_pkg::INDEX_W-1:0] word_index,
  input  wire logic [xs4k_pkg::WORD_W-1:0]  seed_value,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output xs4k_pkg::item_t                   push_item
);
  import xs4k_pkg::*;

  logic low_half_given;
  logic low_half_given_next;
  logic in_range;
  logic accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign in_range   = 32'(word_index) < 32'(STATE_WORDS);

  always_comb begin
    low_half_given_next = low_half_given;
    push_item.op        = OP_NONE;
    push_item.index     = word_index;
    push_item.seed      = seed_value;
    unique case (command)
      CMD_LOAD: begin
        push_item.op = in_range ? OP_LOAD : OP_NONE;
      end
      CMD_STEP: begin
        push_item.op        = OP_STEP;
        low_half_given_next = 1'b0;
      end
      CMD_HALF: begin
        // low half first, high half then steps
        push_item.op        = low_half_given ? OP_HIGH : OP_LOW;
        low_half_given_next = ~low_half_given;
      end
      default: begin
        push_item.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_half_given <= 1'b0;
    end else if (accept) begin
      low_half_given <= low_half_given_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/xs4k_queue.sv */
// ----------------------------------------------------------------------------
// xs4k_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module xs4k_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  xs4k_pkg::item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output xs4k_pkg::item_t pop_item
);
  import xs4k_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/xs4k_ring.sv */
// ----------------------------------------------------------------------------
// xs4k_ring
// state ring, pointer and xorshift word update, one transaction a cycle while results are taken
// ----------------------------------------------------------------------------
`default_nettype none

module xs4k_ring #(
  parameter int STATE_WORDS = xs4k_pkg::STATE_WORDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  xs4k_pkg::cfg_t     cfg,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  xs4k_pkg::item_t    item,
  output logic               res_valid,
  input  wire logic          res_ready,
  output xs4k_pkg::ring_out_t res
);
  import xs4k_pkg::*;

  localparam int PTR_W = $clog2(STATE_WORDS);

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(STATE_WORDS - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [WORD_W-1:0] ring_mem [STATE_WORDS];
  logic [PTR_W-1:0]  ptr;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] rd_data;
  logic              byp;
  logic [WORD_W-1:0] byp_data;

  logic              fire;
  logic              do_step;
  logic              do_load;
  logic [PTR_W-1:0]  ptr_adv;
  logic [PTR_W-1:0]  ptr_next;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  load_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] nxt_word;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] n2;
  logic [WORD_W-1:0] c1;
  logic [WORD_W-1:0] new_word;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    do_step = 1'b0;
    do_load = 1'b0;
    if (fire) begin
      unique case (item.op)
        OP_STEP, OP_HIGH: do_step = 1'b1;
        OP_LOAD:          do_load = 1'b1;
        default:          ;
      endcase
    end
  end

  // prefetched word after the pointer, with write bypass
  assign nxt_word = byp ? byp_data : rd_data;
  assign n1       = nxt_word ^ (nxt_word << cfg.shift_a);
  assign n2       = n1 ^ (n1 >> cfg.shift_b);
  assign c1       = cur_word ^ (cur_word >> cfg.shift_c);
  assign new_word = c1 ^ n2;

  assign ptr_adv   = wrap_inc(ptr);
  assign ptr_next  = do_step ? ptr_adv : ptr;
  assign rd_addr   = wrap_inc(rst ? '0 : ptr_next);
  assign load_addr = PTR_W'(item.index);
  assign wr_en     = !rst && (do_step || do_load);
  assign wr_addr   = do_step ? ptr_adv : load_addr;
  assign wr_data   = do_step ? new_word : item.seed;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    rd_data  <= ring_mem[rd_addr];
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      byp       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      ptr <= ptr_next;
      byp <= wr_en && (wr_addr == rd_addr);
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  // copy of the word under the pointer
  always_ff @(posedge clk) begin
    if (do_step) begin
      cur_word <= new_word;
    end else if (do_load && load_addr == ptr) begin
      cur_word <= item.seed;
    end
    if (fire) begin
      res.op   <= item.op;
      res.word <= new_word;
    end
  end

endmodule

`default_nettype wire

/* hdl/xs4k_scramble.sv */
// ----------------------------------------------------------------------------
// xs4k_scramble
// split 64-bit multiply, bit reversal, held output and result register
// ----------------------------------------------------------------------------
`default_nettype none

module xs4k_scramble (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  xs4k_pkg::cfg_t                   cfg,
  input  wire logic                        src_valid,
  output logic                             src_ready,
  input  xs4k_pkg::ring_out_t              src,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xs4k_pkg::WORD_W-1:0]      random_value
);
  import xs4k_pkg::*;

  logic              b_valid;
  op_t               b_op;
  logic [WORD_W-1:0] p0;
  logic [HALF_W-1:0] p1;
  logic [HALF_W-1:0] p2;
  logic [WORD_W-1:0] p0_next;
  logic [HALF_W-1:0] p1_next;
  logic [HALF_W-1:0] p2_next;

  logic              b_ready;
  logic              c_ready;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] prod_rev;
  logic [WORD_W-1:0] scrambled;
  logic [WORD_W-1:0] last_output;
  logic [WORD_W-1:0] last_output_next;
  logic [WORD_W-1:0] random_value_next;

  assign c_ready   = !out_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign src_ready = b_ready;

  // low 64 bits of the product from three 32-bit partial products
  assign p0_next = src.word[HALF_W-1:0] * cfg.multiplier[HALF_W-1:0];
  assign p1_next = src.word[HALF_W-1:0] * cfg.multiplier[WORD_W-1:HALF_W];
  assign p2_next = src.word[WORD_W-1:HALF_W] * cfg.multiplier[HALF_W-1:0];

  assign prod      = p0 + {p1 + p2, {HALF_W{1'b0}}};
  assign prod_rev  = {<<{prod}};
  assign scrambled = cfg.reverse_enable ? prod_rev : prod;

  always_comb begin
    last_output_next  = last_output;
    random_value_next = '0;
    unique case (b_op)
      OP_STEP: begin
        random_value_next = scrambled;
        last_output_next  = scrambled;
      end
      OP_LOW: begin
        random_value_next = {{HALF_W{1'b0}}, last_output[HALF_W-1:0]};
      end
      OP_HIGH: begin
        random_value_next = {{HALF_W{1'b0}}, last_output[WORD_W-1:HALF_W]};
        last_output_next  = scrambled;
      end
      default: begin
        random_value_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (src_valid && b_ready) begin
      b_op <= src.op;
      p0   <= p0_next;
      p1   <= p1_next;
      p2   <= p2_next;
    end
    if (b_valid && c_ready) begin
      random_value <= random_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
      last_output <= '0;
    end else begin
      if (b_ready) begin
        b_valid <= src_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
      if (b_valid && c_ready) begin
        last_output <= last_output_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/xorshift4096_star_generator.sv */
// ----------------------------------------------------------------------------
// xorshift4096_star_generator
// xorshift-star generator over a ring of 64-bit words with a rotating pointer
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_ready  | command, word_index, seed_value
//  out      | output    | out_valid / out_ready| random_value
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one transaction per clock sustained while out is not stalled; a result
//  passes the queue, ring stage, partial products and result register
//  the rate is set by the ring update: the word after the pointer is
//  prefetched from the single read port, the current word is kept in a register
//  synchronous reset clears pointer, half toggle, held output and queue and
//  resets config; ring words stay undefined until loaded, no clearing pass
//  a stall on out backs up through the pipeline into the queue, and in_ready
//  drops only when the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift4096_star_generator #(
  parameter int STATE_WORDS = xs4k_pkg::STATE_WORDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [xs4k_pkg::CMD_W-1:0]       command,
  input  wire logic [xs4k_pkg::INDEX_W-1:0]     word_index,
  input  wire logic [xs4k_pkg::WORD_W-1:0]      seed_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [xs4k_pkg::WORD_W-1:0]           random_value,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [xs4k_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [xs4k_pkg::WORD_W-1:0]      cfg_data
);
  import xs4k_pkg::*;

  cfg_t      cfg;
  logic      push_valid;
  logic      push_ready;
  item_t     push_item;
  logic      pop_valid;
  logic      pop_ready;
  item_t     pop_item;
  logic      ring_valid;
  logic      ring_ready;
  ring_out_t ring_res;

  // config writes always taken; user issues them only while idle, not enforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_a        <= SHIFT_A_RST;
      cfg.shift_b        <= SHIFT_B_RST;
      cfg.shift_c        <= SHIFT_C_RST;
      cfg.multiplier     <= MULTIPLIER_RST;
      cfg.reverse_enable <= REVERSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHIFT_A:    cfg.shift_a        <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_B:    cfg.shift_b        <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_C:    cfg.shift_c        <= cfg_data[SHIFT_W-1:0];
        REG_MULTIPLIER: cfg.multiplier     <= cfg_data;
        REG_REVERSE:    cfg.reverse_enable <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // front: command decode and half-word toggle
  xs4k_front #(
    .STATE_WORDS (STATE_WORDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .word_index (word_index),
    .seed_value (seed_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  xs4k_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: ring update
  xs4k_ring #(
    .STATE_WORDS (STATE_WORDS)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .res_valid  (ring_valid),
    .res_ready  (ring_ready),
    .res        (ring_res)
  );

  // back: multiply, reverse and result register
  xs4k_scramble u_scramble (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .src_valid    (ring_valid),
    .src_ready    (ring_ready),
    .src          (ring_res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
  );

endmodule

`default_nettype wire
